>>> hw/rtl/two_stacks_shared_array_macros.svh
// ----------------------------------------------------------------------------
// two_stacks_shared_array_macros.svh
// Assertion macros for the two-stack block; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef TWO_STACKS_SHARED_ARRAY_MACROS_SVH
`define TWO_STACKS_SHARED_ARRAY_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TSSA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSSA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TSSA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define TSSA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

>>> hw/rtl/tssa_pkg.sv
// ----------------------------------------------------------------------------
// tssa_pkg
// Types, codes and constants shared by the two-stack block.
// ----------------------------------------------------------------------------
package tssa_pkg;

    localparam int unsigned DEPTH_DEF = 1024;
    localparam int unsigned CNT_W     = 11;
    localparam int unsigned DATA_W    = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [1:0] CMD_PUSH_LO = 2'd0;
    localparam logic [1:0] CMD_PUSH_HI = 2'd1;
    localparam logic [1:0] CMD_POP_LO  = 2'd2;
    localparam logic [1:0] CMD_POP_HI  = 2'd3;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        logic [1:0]               status;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } ctrl_state_t;

endpackage

>>> hw/rtl/two_stacks_shared_array.sv
// ----------------------------------------------------------------------------
// two_stacks_shared_array
// Two LIFO stacks sharing one store, one growing up and one growing down.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carry a request: cmd (push low, push high, pop low,
//   pop high) and push_value. m_valid/m_ready/m_item return one result per
//   request: pop_value and status (done, full, empty).
//   cfg_valid/cfg_ready/cfg_data write the capacity; cfg_ready is always high.
//   Writing the capacity empties both stacks. Write it only while idle.
// Timing:
//   a request is taken in the idle cycle, runs on the datapath in the next
//   cycle (at most one store write or one store read), and its result is
//   shown from the cycle after that and held until m_ready is high.
//   One request at a time: a new request is taken only after the result of
//   the last one has been accepted.
// Reset:
//   counts clear and capacity returns to 1024; store contents are left as is.
// Stall:
//   while m_ready is low the result is held and s_ready stays low.
// ----------------------------------------------------------------------------
`include "two_stacks_shared_array_macros.svh"

module two_stacks_shared_array
    import tssa_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_item
);

    ctrl_cmd_t ctrl_cmd;

    assign cfg_ready = 1'b1;

    tssa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .ctrl_cmd (ctrl_cmd)
    );

    tssa_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_item    (s_item),
        .m_item    (m_item),
        .ctrl_cmd  (ctrl_cmd)
    );

    `TSSA_ASSERT_IMPL(a_no_take_while_pending, aclk, aresetn, m_valid, !s_ready, "request taken while result pending")
    `TSSA_ASSERT_IMPL(a_result_latency, aclk, aresetn, s_valid && s_ready, ##2 m_valid, "result not shown two cycles after request")
    `TSSA_ASSERT_NEXT(a_result_once, aclk, aresetn, m_valid && m_ready, !m_valid, "result repeated after handshake")
    `TSSA_ASSERT_IMPL(a_empty_value, aclk, aresetn, m_valid && m_item.status == STATUS_EMPTY, m_item.pop_value == -32'sd1, "empty pop without minus one")

endmodule

>>> hw/rtl/tssa_ctrl.sv
// ----------------------------------------------------------------------------
// tssa_ctrl
// Request sequencer: take a request, run it on the datapath, hold the result.
// ----------------------------------------------------------------------------
module tssa_ctrl
    import tssa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output ctrl_cmd_t ctrl_cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        ctrl_cmd.load = 1'b0;
        ctrl_cmd.exec = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl_cmd.load = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ctrl_cmd.exec = 1'b1;
                state_next    = ST_RESP;
            end
            ST_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/tssa_dp.sv
// ----------------------------------------------------------------------------
// tssa_dp
// Stack store, stack counters, capacity register and result registers.
// ----------------------------------------------------------------------------
module tssa_dp
    import tssa_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [CNT_W-1:0] cfg_data,
    input  in_item_t         s_item,
    output out_item_t        m_item,
    input  ctrl_cmd_t        ctrl_cmd
);

    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned IW     = (ADDR_W > CNT_W) ? ADDR_W : CNT_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cnt_lo_reg, cnt_lo_next;
    logic [CNT_W-1:0] cnt_hi_reg, cnt_hi_next;
    in_item_t         req_reg;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic             rd_sel_reg, rd_sel_next;

    logic [CNT_W-1:0] eff_cap;
    logic [CNT_W:0]   used;
    logic             has_room;
    logic             wr_en, rd_en;
    logic [CNT_W-1:0] wr_idx, rd_idx;
    logic [IW-1:0]    wr_idx_ext, rd_idx_ext;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    // capacity saturates at the store depth
    always_comb begin
        if (32'(cap_reg) > 32'(DEPTH)) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = cap_reg;
        end
    end

    assign used     = {1'b0, cnt_lo_reg} + {1'b0, cnt_hi_reg};
    assign has_room = used < {1'b0, eff_cap};

    always_comb begin
        cnt_lo_next     = cnt_lo_reg;
        cnt_hi_next     = cnt_hi_reg;
        out_data_next   = '0;
        out_status_next = STATUS_DONE;
        rd_sel_next     = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        wr_idx          = cnt_lo_reg;
        rd_idx          = cnt_lo_reg - 1'b1;
        case (req_reg.cmd)
            CMD_PUSH_LO: begin
                if (has_room) begin
                    wr_en       = 1'b1;
                    wr_idx      = cnt_lo_reg;
                    cnt_lo_next = cnt_lo_reg + 1'b1;
                end else begin
                    out_status_next = STATUS_FULL;
                end
            end
            CMD_PUSH_HI: begin
                if (has_room) begin
                    wr_en       = 1'b1;
                    cnt_hi_next = cnt_hi_reg + 1'b1;
                    wr_idx      = eff_cap - cnt_hi_next;
                end else begin
                    out_status_next = STATUS_FULL;
                end
            end
            CMD_POP_LO: begin
                if (cnt_lo_reg != '0) begin
                    rd_en       = 1'b1;
                    rd_sel_next = 1'b1;
                    rd_idx      = cnt_lo_reg - 1'b1;
                    cnt_lo_next = cnt_lo_reg - 1'b1;
                end else begin
                    out_data_next   = '1;
                    out_status_next = STATUS_EMPTY;
                end
            end
            CMD_POP_HI: begin
                if (cnt_hi_reg != '0 && cnt_hi_reg <= eff_cap) begin
                    rd_en       = 1'b1;
                    rd_sel_next = 1'b1;
                    rd_idx      = eff_cap - cnt_hi_reg;
                    cnt_hi_next = cnt_hi_reg - 1'b1;
                end else begin
                    out_data_next   = '1;
                    out_status_next = STATUS_EMPTY;
                end
            end
            default: begin
                out_status_next = STATUS_DONE;
            end
        endcase
    end

    // indices stay below the effective capacity, so they fit the address
    assign wr_idx_ext = IW'(wr_idx);
    assign rd_idx_ext = IW'(rd_idx);
    assign wr_addr    = wr_idx_ext[ADDR_W-1:0];
    assign rd_addr    = rd_idx_ext[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (ctrl_cmd.exec && wr_en) begin
            mem[wr_addr] <= req_reg.push_value;
        end
        if (ctrl_cmd.exec && rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= CAP_RESET;
            cnt_lo_reg <= '0;
            cnt_hi_reg <= '0;
        end else if (cfg_valid) begin
            // new capacity empties both stacks
            cap_reg    <= cfg_data;
            cnt_lo_reg <= '0;
            cnt_hi_reg <= '0;
        end else if (ctrl_cmd.exec) begin
            cnt_lo_reg <= cnt_lo_next;
            cnt_hi_reg <= cnt_hi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_cmd.load) begin
            req_reg <= s_item;
        end
        if (ctrl_cmd.exec) begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
            rd_sel_reg     <= rd_sel_next;
        end
    end

    assign m_item.pop_value = rd_sel_reg ? rdata_reg : out_data_reg;
    assign m_item.status    = out_status_reg;

endmodule

>>> bench/two_stacks_shared_array_tb.sv
// ----------------------------------------------------------------------------
// two_stacks_shared_array_tb
// Drives push and pop requests into the two-stack block and checks every
// result against a scoreboard that tracks both stacks, the shared store and
// the capacity, through directed corner cases and random bursts at several
// capacities, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module two_stacks_shared_array_tb;
    import tssa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_DEPTH = DEPTH_DEF;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned HOLD_CYCLES = 200;

    class stack_scoreboard;
        logic [DATA_W-1:0] mem [STORE_DEPTH];
        int unsigned lo_count;
        int unsigned hi_count;
        int unsigned cap_reg;
        out_item_t expected_q [$];
        int errors;
        int n_requests;
        int n_done;
        int n_full;
        int n_empty;

        function new();
            cap_reg = 32'(CAP_RESET);
            lo_count = 0;
            hi_count = 0;
            errors = 0;
            n_requests = 0;
            n_done = 0;
            n_full = 0;
            n_empty = 0;
        endfunction

        // a capacity write empties both stacks
        function void set_capacity(input logic [CNT_W-1:0] cap);
            cap_reg = 32'(cap);
            lo_count = 0;
            hi_count = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(input in_item_t req);
            int unsigned cap;
            out_item_t res;
            cap = (cap_reg > STORE_DEPTH) ? STORE_DEPTH : cap_reg;
            res.pop_value = '0;
            res.status = STATUS_DONE;
            n_requests++;
            case (req.cmd)
                CMD_PUSH_LO: begin
                    if (lo_count + hi_count < cap) begin
                        mem[lo_count] = req.push_value;
                        lo_count++;
                    end else begin
                        res.status = STATUS_FULL;
                    end
                end
                CMD_PUSH_HI: begin
                    if (lo_count + hi_count < cap) begin
                        hi_count++;
                        mem[cap - hi_count] = req.push_value;
                    end else begin
                        res.status = STATUS_FULL;
                    end
                end
                CMD_POP_LO: begin
                    if (lo_count > 0) begin
                        lo_count--;
                        res.pop_value = mem[lo_count];
                    end else begin
                        res.pop_value = '1;
                        res.status = STATUS_EMPTY;
                    end
                end
                default: begin
                    if (hi_count > 0 && hi_count <= cap) begin
                        res.pop_value = mem[cap - hi_count];
                        hi_count--;
                    end else begin
                        res.pop_value = '1;
                        res.status = STATUS_EMPTY;
                    end
                end
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_result(input out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: pop_value %h status %0d",
                       got.pop_value, got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.pop_value !== want.pop_value) begin
                $error("pop_value: expected %h, actual %h", want.pop_value, got.pop_value);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            case (want.status)
                STATUS_FULL:  n_full++;
                STATUS_EMPTY: n_empty++;
                default:      n_done++;
            endcase
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_item;

    stack_scoreboard sb = new();
    bit idle_on = 1'b1;
    bit result_taken = 1'b0;
    bit hold_go = 1'b0;
    bit hold_active = 1'b0;
    int ready_wait = 0;
    int cycle_count = 0;
    int n_cap_writes = 0;

    two_stacks_shared_array dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always #2 aclk = ~aclk;

    // note each accepted request before checking results of the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(s_item);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_item);
            end
        end
        result_taken = aresetn && m_valid && m_ready;
    end

    always @(negedge aclk) begin
        if (result_taken) begin
            ready_wait = idle_on ? $urandom_range(0, 6) : 0;
        end
        if (hold_active) begin
            m_ready <= 1'b0;
        end else if (ready_wait > 0) begin
            m_ready <= 1'b0;
            ready_wait--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // long receiver stall so the block backs up and stalls its input
    // starts at the capacity write so the sender keeps offering meanwhile
    initial begin
        wait (hold_go);
        wait (cfg_valid);
        @(posedge aclk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active = 1'b0;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("two_stacks_shared_array_tb NOT OK");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [1:0] cmd, input logic [DATA_W-1:0] value);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item.cmd <= cmd;
        s_item.push_value <= value;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        drain_results();
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_capacity(cap);
        n_cap_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t random_request(input int push_pct);
        in_item_t req;
        bit to_hi;
        to_hi = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < push_pct) begin
            req.cmd = to_hi ? CMD_PUSH_HI : CMD_PUSH_LO;
        end else begin
            req.cmd = to_hi ? CMD_POP_HI : CMD_POP_LO;
        end
        case ($urandom_range(0, 7))
            0:       req.push_value = 32'h7FFF_FFFF;
            1:       req.push_value = 32'h8000_0000;
            2:       req.push_value = '1;
            3:       req.push_value = '0;
            default: req.push_value = $urandom;
        endcase
        return req;
    endfunction

    // bursts that lean toward pushes or pops so both stacks fill and empty
    task automatic run_phase(input logic [CNT_W-1:0] cap, input int n_items, input bit idle);
        int push_pct;
        int burst;
        in_item_t req;
        write_capacity(cap);
        idle_on = idle;
        burst = 0;
        push_pct = 50;
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) begin
                drain_results();
            end
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                push_pct = $urandom_range(0, 1) ? 80 : 25;
            end
            burst--;
            req = random_request(push_pct);
            send_request(req.cmd, req.push_value);
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset capacity: empty pops, extreme values, lifo order on both sides
        send_request(CMD_POP_LO, 32'h0000_0000);
        send_request(CMD_POP_HI, 32'hFFFF_FFFF);
        send_request(CMD_PUSH_LO, 32'h7FFF_FFFF);
        send_request(CMD_PUSH_LO, 32'h8000_0000);
        send_request(CMD_PUSH_HI, 32'hFFFF_FFFF);
        send_request(CMD_PUSH_HI, 32'h0000_0000);
        send_request(CMD_POP_LO, 32'h1234_5678);
        send_request(CMD_POP_HI, 32'h0);
        send_request(CMD_POP_HI, 32'h0);
        send_request(CMD_POP_LO, 32'h0);
        send_request(CMD_POP_LO, 32'h0);

        // zero capacity: nothing fits
        write_capacity(11'd0);
        send_request(CMD_PUSH_LO, 32'hDEAD_BEEF);
        send_request(CMD_PUSH_HI, 32'hDEAD_BEEF);
        send_request(CMD_POP_LO, 32'h0);
        send_request(CMD_POP_HI, 32'h0);

        // single entry shared by both stacks
        write_capacity(11'd1);
        send_request(CMD_PUSH_HI, 32'hA5A5_A5A5);
        send_request(CMD_PUSH_LO, 32'h5A5A_5A5A);
        send_request(CMD_POP_LO, 32'h0);
        send_request(CMD_POP_HI, 32'h0);
        send_request(CMD_POP_HI, 32'h0);

        // capacity above the store size saturates
        write_capacity(11'h7FF);
        send_request(CMD_PUSH_LO, 32'h1234_5678);
        send_request(CMD_PUSH_HI, 32'h8765_4321);

        // capacity write with both stacks holding entries empties them
        write_capacity(11'd2);
        send_request(CMD_POP_LO, 32'h0);
        send_request(CMD_POP_HI, 32'h0);
        send_request(CMD_PUSH_LO, 32'h0F0F_0F0F);

        run_phase(11'd3, 150, 1'b1);
        run_phase(11'd1, 60, 1'b1);
        run_phase(11'd2, 80, 1'b0);
        run_phase(11'd0, 30, 1'b1);
        hold_go = 1'b1;
        run_phase(11'd8, 150, 1'b1);
        run_phase(11'd1025, 150, 1'b1);
        run_phase(11'($urandom_range(1, 16)), 150, 1'b1);
        run_phase(11'd5, 100, 1'b0);
        run_phase(11'd1024, 100, 1'b1);
        run_phase(11'($urandom_range(0, 2047)), 80, 1'b1);

        // saturated capacity: the high stack starts at the top of the store
        run_phase(11'h7FF, 120, 1'b1);

        drain_results();
        repeat (8) @(negedge aclk);
        $display("covered %0d requests over %0d capacity writes", sb.n_requests,
                 n_cap_writes);
        $display("results: %0d done, %0d dropped pushes, %0d empty pops",
                 sb.n_done, sb.n_full, sb.n_empty);
        if (sb.errors == 0) begin
            $display("two_stacks_shared_array_tb OK");
        end else begin
            $display("two_stacks_shared_array_tb NOT OK");
        end
        $finish;
    end

endmodule
